// ===== rtl/cpdt_pkg.sv =====
// shared constants, types and the entry compare function for the constant pool table
package cpdt_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 64;
  localparam int INDEX_W    = 10;
  localparam int ENTRY_W    = KIND_W + VALUE_W;

  // constant kinds
  localparam logic [KIND_W-1:0] KIND_STRING = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLOAT  = 2'd2;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // float64 field masks
  localparam logic [VALUE_W-1:0] ABS_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
  localparam logic [VALUE_W-1:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_RESP
  } cpdt_state_t;

  // ieee double nan: exponent all ones, fraction nonzero
  function automatic logic is_nan64(input logic [VALUE_W-1:0] b);
    is_nan64 = ((b & EXP_MASK) == EXP_MASK) && ((b & FRAC_MASK) != '0);
  endfunction

  // shared compare unit: kinds equal and values equal under the kind's rule
  function automatic logic entry_match(
    input logic [KIND_W-1:0]  req_kind,
    input logic [VALUE_W-1:0] req_value,
    input logic [KIND_W-1:0]  ent_kind,
    input logic [VALUE_W-1:0] ent_value
  );
    logic same_bits;
    logic both_zero;
    logic any_nan;
    same_bits = (req_value == ent_value);
    both_zero = ((req_value & ABS_MASK) == '0) && ((ent_value & ABS_MASK) == '0);
    any_nan   = is_nan64(req_value) || is_nan64(ent_value);
    if (req_kind != ent_kind) begin
      entry_match = 1'b0;
    end else if (req_kind == KIND_FLOAT) begin
      entry_match = !any_nan && (both_zero || same_bits);
    end else begin
      entry_match = same_bits;
    end
  endfunction

endpackage

// ===== rtl/cpdt_if.sv =====
// request and result channel interfaces for the constant pool table
interface cpdt_req_if;
  import cpdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  req_type;
  logic [VALUE_W-1:0] const_value;
  modport source (output valid, output req_type, output const_value, input ready);
  modport sink   (input valid, input req_type, input const_value, output ready);
endinterface

interface cpdt_rsp_if;
  import cpdt_pkg::*;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] pool_index;
  logic               status;
  modport source (output valid, output pool_index, output status, input ready);
  modport sink   (input valid, input pool_index, input status, output ready);
endinterface

// ===== rtl/cpdt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module cpdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/constant_pool_dedup_table.sv =====
// constant pool deduplication table: linear scan of a ram-held pool, append on miss if room
//
//   channel  | dir | handshake     | payload
//   in_req   | in  | valid / ready | req_type[1:0], const_value[63:0]
//   out_rsp  | out | valid / ready | pool_index[9:0], status
//
// one request at a time: the scan reads one entry per cycle and compares it the next;
// a hit returns that entry's index; a miss appends the value and returns its new index,
// or status full with index 0 when the pool is already full
// reset (rst_n low, synchronous) clears count, state, flags; higher entries are never read
// in_req.ready is high only while idle; a stalled result sits in the output register
// and the next finished result waits behind it, which holds off in_req
module constant_pool_dedup_table (
  input  logic       clk,
  input  logic       rst_n,
  cpdt_req_if.sink   in_req,
  cpdt_rsp_if.source out_rsp
);
  import cpdt_pkg::*;

  cpdt_state_t        state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic               status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_status_r, out_status_nxt;

  logic               ram_re;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               hit;

  // pool storage: kind and value side by side
  cpdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({kind_r, value_r}),
    .rd_en   (ram_re),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  // compare of the entry read last cycle
  assign hit = pend_r && entry_match(kind_r, value_r,
                                     ram_rdata[ENTRY_W-1:VALUE_W],
                                     ram_rdata[VALUE_W-1:0]);

  // channel outputs
  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.pool_index = out_idx_r;
  assign out_rsp.status     = out_status_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    index_nxt      = index_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          kind_nxt  = in_req.req_type;
          value_nxt = in_req.const_value;
          issue_nxt = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt = 1'b0;
        priority if (hit) begin
          index_nxt  = INDEX_W'(pend_idx_r);
          status_nxt = STATUS_OK;
          state_nxt  = ST_RESP;
        end else if (issue_r < count_r) begin
          ram_re       = 1'b1;
          issue_nxt    = issue_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = issue_r[IDX_W-1:0];
        end else if (!pend_r) begin
          if (count_r == CNT_W'(POOL_DEPTH)) begin
            index_nxt  = '0;
            status_nxt = STATUS_FULL;
            state_nxt  = ST_RESP;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        ram_we     = 1'b1;
        count_nxt  = count_r + 1'b1;
        index_nxt  = INDEX_W'(count_r);
        status_nxt = STATUS_OK;
        state_nxt  = ST_RESP;
      end
      ST_RESP: begin
        // move the result into the output register once it is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_idx_nxt    = index_r;
          out_status_nxt = status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    value_r      <= value_nxt;
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    index_r      <= index_nxt;
    status_r     <= status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
  end

  // entry count stays within the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_DEPTH))
    else $error("entry count above pool depth");

  // the count only ever grows by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> count_r == $past(count_r) + 1'b1)
    else $error("entry count moved by other than one");

  // a full status only when the pool is really full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && (out_rsp.status == STATUS_FULL) |->
      (count_r == CNT_W'(POOL_DEPTH)) && (out_rsp.pool_index == '0))
    else $error("pool-full result with free entries");

  // appends never go past the last entry
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> count_r < CNT_W'(POOL_DEPTH))
    else $error("append into a full pool");

  // a stalled result stays put until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=>
      out_rsp.valid && $stable(out_rsp.pool_index) && $stable(out_rsp.status))
    else $error("result changed while stalled");

endmodule
